/* hdl/paq_pkg.sv */
package paq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam logic [31:0] TX_SPACING_RESET = 32'd1000;

  typedef enum logic {
    REQ_ENQUEUE  = 1'b0,
    REQ_TRANSMIT = 1'b1
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_EVICTED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_SENT    = 3'd3,
    ST_PACED   = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_REFUSED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  priority_req;
    logic [31:0] dest_node;
    logic [2:0]  channel_num;
    logic [15:0] payload_handle;
    logic [31:0] now_ms;
    logic        sink_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_index;
    logic [1:0]  out_priority;
    logic [31:0] out_dest;
    logic [2:0]  out_channel;
    logic [15:0] out_payload;
  } rsp_t;

  // one slot of the alert store
  typedef struct packed {
    logic [1:0]  prio;
    logic [31:0] dest;
    logic [2:0]  chan;
    logic [15:0] payload;
  } entry_t;

endpackage

/* hdl/paq_slot_mem.sv */
module paq_slot_mem
  import paq_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/paq_ctrl.sv */
module paq_ctrl
  import paq_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  req_t            req_i,
  input  logic [31:0]     spacing_i,
  output logic            busy_o,
  output logic            rsp_valid_o,
  output rsp_t            rsp_o,
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output entry_t          mem_wdata_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  entry_t          mem_rdata_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  state_e          state_q, state_d;
  logic [Depth-1:0] used_q, used_d;
  logic [31:0]     last_q, last_d;
  logic            issue_q, issue_d;
  logic            chk_vld_q;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] chk_idx_q;

  req_t            req_q;
  logic            paced_q;
  logic            found_q;
  logic [IdxW-1:0] slot_q;
  logic [1:0]      lowest_q;
  logic            victim_vld_q;
  logic [IdxW-1:0] victim_q;
  logic [1:0]      best_q;
  entry_t          sel_q;

  logic            accept;
  logic            paced;
  logic [31:0]     elapsed;
  logic            is_tx;
  logic            cur_used;
  logic            scan_last;

  assign accept    = start_i && (state_q == S_IDLE);
  assign elapsed   = req_i.now_ms - last_q;
  assign paced     = (req_i.req_type == REQ_TRANSMIT) && (elapsed < spacing_i);
  assign is_tx     = (req_q.req_type == REQ_TRANSMIT);
  assign cur_used  = used_q[chk_idx_q];
  assign scan_last = chk_vld_q && (chk_idx_q == LastIdx);
  assign busy_o    = (state_q != S_IDLE);
  assign mem_raddr_o = rd_idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = paced ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // read issue and result, write back
  always_comb begin
    issue_d     = issue_q;
    rd_idx_d    = rd_idx_q;
    used_d      = used_q;
    last_d      = last_q;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_q;
    mem_wdata_o = '{prio: req_q.priority_req, dest: req_q.dest_node,
                    chan: req_q.channel_num, payload: req_q.payload_handle};
    unique case (state_q)
      S_IDLE: begin
        if (accept && !paced) begin
          issue_d  = 1'b1;
          rd_idx_d = '0;
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          if (rd_idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        rsp_valid_o = 1'b1;
        if (!is_tx) begin
          if (found_q) begin
            rsp_o.status     = ST_STORED;
            rsp_o.slot_index = 3'(slot_q);
            mem_we_o         = 1'b1;
            used_d[slot_q]   = 1'b1;
          end else if (victim_vld_q && (req_q.priority_req > lowest_q)) begin
            rsp_o.status     = ST_EVICTED;
            rsp_o.slot_index = 3'(victim_q);
            mem_we_o         = 1'b1;
            mem_waddr_o      = victim_q;
            used_d[victim_q] = 1'b1;
          end else begin
            rsp_o.status = ST_DROPPED;
          end
        end else if (paced_q) begin
          rsp_o.status = ST_PACED;
        end else if (!found_q) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          rsp_o.status       = req_q.sink_ok ? ST_SENT : ST_REFUSED;
          rsp_o.slot_index   = 3'(slot_q);
          rsp_o.out_priority = sel_q.prio;
          rsp_o.out_dest     = sel_q.dest;
          rsp_o.out_channel  = sel_q.chan;
          rsp_o.out_payload  = sel_q.payload;
          if (req_q.sink_ok) begin
            used_d[slot_q] = 1'b0;
            last_d         = req_q.now_ms;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      last_q    <= '0;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      last_q    <= last_d;
      issue_q   <= issue_d;
      chk_vld_q <= (state_q == S_SCAN) && issue_q;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // scan datapath: read data for slot chk_idx_q arrives in the cycle after its address
  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx_q;
    if (accept) begin
      req_q        <= req_i;
      paced_q      <= paced;
      found_q      <= 1'b0;
      lowest_q     <= 2'd3;
      victim_vld_q <= 1'b0;
      best_q       <= 2'd0;
    end else if (state_q == S_SCAN && chk_vld_q) begin
      if (!is_tx) begin
        // first free slot wins; otherwise track the last slot of lowest priority
        if (!found_q) begin
          if (!cur_used) begin
            found_q <= 1'b1;
            slot_q  <= chk_idx_q;
          end else if (mem_rdata_i.prio <= lowest_q) begin
            lowest_q     <= mem_rdata_i.prio;
            victim_q     <= chk_idx_q;
            victim_vld_q <= 1'b1;
          end
        end
      end else if (cur_used && (!found_q || (mem_rdata_i.prio > best_q))) begin
        found_q <= 1'b1;
        slot_q  <= chk_idx_q;
        best_q  <= mem_rdata_i.prio;
        sel_q   <= mem_rdata_i;
      end
    end
  end

endmodule

/* hdl/priority_alert_queue_paced_unit.sv */
// Channel   Ports                      Direction  Transfer
// request   start_i, req_i, busy_o     in         start_i high while busy_o low
// result    rsp_valid_o, rsp_o         out        rsp_valid_o high, one cycle
// config    cfg_we_i, cfg_wdata_i      in         cfg_we_i high
//
// A request passes these steps before the next transfer can be taken: the slot
// memory is scanned one slot per cycle through its single read port, the read
// data is registered and checked, then come the write-back cycle and the return
// to idle; busy_o stays high from the scan through the write-back cycle.
// A transmit request held off by pacing skips the scan and goes to write-back.
// The result shows in the write-back cycle, the last cycle with busy_o high.
// Reset empties the queue, zeroes the last send time and sets the spacing to 1000.
// The receiver cannot stall results.
module priority_alert_queue_paced_unit
  import paq_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic [31:0]     spacing_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_wdata;
  entry_t          mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= TX_SPACING_RESET;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  paq_slot_mem #(
    .Depth(QueueDepth)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  paq_ctrl #(
    .Depth(QueueDepth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .spacing_i  (spacing_q),
    .busy_o     (busy_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

endmodule
